// ===== rtl/sts_pkg.sv =====
// Shared types and constants of the sorted table range search block.
package sts_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KEY_BITS       = 32;
    localparam int INDEX_BITS     = 8;
    localparam int COUNT_BITS     = 9;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                        operation;
        logic [INDEX_BITS-1:0]       load_index;
        logic signed [KEY_BITS-1:0]  load_value;
        logic signed [KEY_BITS-1:0]  key_low;
        logic signed [KEY_BITS-1:0]  key_high;
    } sts_in_t;

    typedef struct packed {
        logic                  first_found;
        logic [INDEX_BITS-1:0] first_index;
        logic                  last_found;
        logic [INDEX_BITS-1:0] last_index;
    } sts_out_t;

    // Status of the shared probe unit
    typedef struct packed {
        logic active;   // search window still holds entries
        logic go_left;  // key sorts before the probed entry, or at it when not strict
    } sts_probe_t;

endpackage

// ===== rtl/sts_table.sv =====
// Table memory: one write port, one registered read port.
module sts_table
    import sts_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sts_probe.sv =====
// Shared probe unit: window midpoint, signed key compare and window step.
module sts_probe
    import sts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = KEY_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW   = AW + 1
) (
    input  logic [NW-1:0]        lo,
    input  logic [NW-1:0]        hi,
    input  logic [AW-1:0]        idx,
    input  logic signed [CW-1:0] key,
    input  logic signed [CW-1:0] ent,
    input  logic                 strict,
    output logic [AW-1:0]        mid,
    output logic [NW-1:0]        idx_inc,
    output sts_probe_t           st
);

    logic [NW:0] sum;

    assign sum        = {1'b0, lo} + {1'b0, hi};
    assign mid        = sum[AW:1];
    assign idx_inc    = NW'(idx) + NW'(1);
    assign st.active  = (lo < hi);
    assign st.go_left = strict ? (key < ent) : (key <= ent);

endmodule

// ===== rtl/sorted_table_range_search_top.sv =====
// Top level of the sorted table range search block: sequencer and ports.
//
// Use: software loads a table of signed values, sorted ascending, one entry
// per load request (operation = load) and sets entries_in_use through the
// configuration port (cfg_wr_en / cfg_wr_data, no wait). A query request
// gives key_low and key_high and gets exactly one result: the lower bound of
// key_low and the last entry not greater than key_high. Loads give none.
// Channels: s_valid/s_ready carry requests, m_valid/m_ready carry results.
// Flow: a load needs no sequencer step and the next request can follow at
// once. A query runs two binary searches through one shared probe unit and
// the single read port of the table memory; every probe is an address step,
// then a compare on registered read data. Each search makes at most
// log2(entries)+1 probes. Keys out of order skip the second search.
// The block takes no new request while a query is under way.
// Reset (aresetn, synchronous, active low) clears the sequencer, the output
// valid and entries_in_use; the table memory is not cleared and must be
// written before it is searched.
// Stall: a finished result waits in the output register; loads are still
// accepted meanwhile, and a following query holds in its last step until
// the pending result is taken.
module sorted_table_range_search_top
    import sts_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sts_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sts_out_t              m_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW   = AW + 1;
    localparam int CW   = (VALUE_BITS > KEY_BITS) ? VALUE_BITS : KEY_BITS;
    localparam int CNTW = (NW > COUNT_BITS) ? NW : COUNT_BITS;
    localparam int IW   = (NW > INDEX_BITS) ? NW : INDEX_BITS;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_LB_ADDR = 7'b0000010,
        ST_LB_CMP  = 7'b0000100,
        ST_KEYCHK  = 7'b0001000,
        ST_UB_ADDR = 7'b0010000,
        ST_UB_CMP  = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] entries_reg;
    logic [NW-1:0]         lo_reg, lo_next;
    logic [NW-1:0]         hi_reg, hi_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         start_reg, start_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic signed [KEY_BITS-1:0] k1_reg, k1_next;
    logic signed [KEY_BITS-1:0] k2_reg, k2_next;
    logic                  ff_reg, ff_next;
    logic                  lf_reg, lf_next;
    logic [INDEX_BITS-1:0] li_reg, li_next;
    logic                  m_valid_reg, m_valid_next;
    sts_out_t              m_data_reg, m_data_next;

    logic                  accept;
    logic                  is_load;
    logic [31:0]           rem;
    logic [AW-1:0]         wr_addr;
    logic signed [CW-1:0]  lv_ext;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  rd_en;
    logic [CNTW-1:0]       cnt_ext;
    logic [CNTW-1:0]       cnt_sat;
    logic signed [CW-1:0]  key_op;
    logic signed [CW-1:0]  ent_op;
    logic                  strict;
    logic [AW-1:0]         mid;
    logic [NW-1:0]         idx_inc;
    sts_probe_t            pst;
    logic [IW-1:0]         start_ext;
    logic [IW-1:0]         last_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_load = (s_data.operation == OP_LOAD);

    // Fold the load position into the table: restoring remainder by DEPTH
    always_comb begin
        rem = 32'(s_data.load_index);
        for (int k = INDEX_BITS - 1; k >= 0; k--) begin
            if (rem >= (32'(DEPTH) << k)) begin
                rem = rem - (32'(DEPTH) << k);
            end
        end
    end
    assign wr_addr = rem[AW-1:0];
    assign lv_ext  = CW'(s_data.load_value);

    // Saturate the entry count to the table depth
    assign cnt_ext = CNTW'(entries_reg);
    assign cnt_sat = (cnt_ext > CNTW'(DEPTH)) ? CNTW'(DEPTH) : cnt_ext;

    sts_table #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (accept && is_load),
        .wr_addr (wr_addr),
        .wr_data (lv_ext[VALUE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (mid),
        .rd_data (rd_data)
    );

    // Operand select for the shared probe unit
    always_comb begin
        key_op = CW'(k1_reg);
        ent_op = CW'($signed(rd_data));
        strict = 1'b0;
        if (state_reg == ST_KEYCHK) begin
            ent_op = CW'(k2_reg);
        end else if (state_reg == ST_UB_CMP) begin
            key_op = CW'(k2_reg);
            strict = 1'b1;
        end
    end

    sts_probe #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_probe (
        .lo      (lo_reg),
        .hi      (hi_reg),
        .idx     (idx_reg),
        .key     (key_op),
        .ent     (ent_op),
        .strict  (strict),
        .mid     (mid),
        .idx_inc (idx_inc),
        .st      (pst)
    );

    assign start_ext = IW'(start_reg);
    assign last_ext  = IW'(lo_reg - NW'(1));

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        n_next       = n_reg;
        start_next   = start_reg;
        idx_next     = idx_reg;
        k1_next      = k1_reg;
        k2_next      = k2_reg;
        ff_next      = ff_reg;
        lf_next      = lf_reg;
        li_next      = li_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && !is_load) begin
                    k1_next    = s_data.key_low;
                    k2_next    = s_data.key_high;
                    n_next     = cnt_sat[NW-1:0];
                    lo_next    = '0;
                    hi_next    = cnt_sat[NW-1:0];
                    state_next = ST_LB_ADDR;
                end
            end
            ST_LB_ADDR: begin
                if (pst.active) begin
                    rd_en      = 1'b1;
                    idx_next   = mid;
                    state_next = ST_LB_CMP;
                end else begin
                    start_next = lo_reg;
                    ff_next    = (lo_reg < n_reg);
                    state_next = ST_KEYCHK;
                end
            end
            ST_LB_CMP: begin
                if (pst.go_left) begin
                    hi_next = NW'(idx_reg);
                end else begin
                    lo_next = idx_inc;
                end
                state_next = ST_LB_ADDR;
            end
            ST_KEYCHK: begin
                // Keys in order: search for the upper bound from the lower one; else finish
                lf_next = 1'b0;
                li_next = '0;
                if (pst.go_left) begin
                    hi_next    = n_reg;
                    state_next = ST_UB_ADDR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UB_ADDR: begin
                if (pst.active) begin
                    rd_en      = 1'b1;
                    idx_next   = mid;
                    state_next = ST_UB_CMP;
                end else begin
                    if (lo_reg > start_reg) begin
                        lf_next = 1'b1;
                        li_next = last_ext[INDEX_BITS-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_UB_CMP: begin
                if (pst.go_left) begin
                    hi_next = NW'(idx_reg);
                end else begin
                    lo_next = idx_inc;
                end
                state_next = ST_UB_ADDR;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.first_found = ff_reg;
                    m_data_next.first_index = ff_reg ? start_ext[INDEX_BITS-1:0] : '0;
                    m_data_next.last_found  = lf_reg;
                    m_data_next.last_index  = li_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            entries_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                entries_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        n_reg      <= n_next;
        start_reg  <= start_next;
        idx_reg    <= idx_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        ff_reg     <= ff_next;
        lf_reg     <= lf_next;
        li_reg     <= li_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The sequencer stays one-hot
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // A compare step always follows its address step
    a_cmp_after_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LB_CMP || state_reg == ST_UB_CMP) |->
        ($past(state_reg) == ST_LB_ADDR || $past(state_reg) == ST_UB_ADDR))
        else $error("compare step without a read");

    // The search window stays ordered and inside the table in use
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LB_ADDR || state_reg == ST_UB_ADDR) |->
        (lo_reg <= hi_reg && hi_reg <= n_reg))
        else $error("search window out of order");

    // A nonempty range implies a lower bound inside the table
    a_last_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.last_found || m_data_reg.first_found))
        else $error("last entry found without a lower bound");

endmodule
